// ===== sv/rldr_pkg.sv =====
`default_nettype none

package rldr_pkg;

   // Field and datapath widths.
   localparam int COORD_W   = 13;
   localparam int CTR_W     = 17;
   localparam int DIM_W     = 14;
   localparam int K_W       = 64;
   localparam int DX_W      = 18;
   localparam int SQ_W      = 34;
   localparam int R2_W      = 35;
   localparam int PROD_W    = 100;
   localparam int POS_W     = 84;
   localparam int INT_W     = 16;
   localparam int FRAC_W    = 8;
   localparam int CSR_IDX_W = 3;

   // Binary point positions and the scaling shifts of the gain terms.
   localparam int GAIN_FRAC = 32;
   localparam int POS_FRAC  = 36;
   localparam int T_SHIFT   = 36;
   localparam int B_SHIFT   = 8;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_OUT_CX = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_CY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_CX = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_CY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_K1     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_K2     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_W  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_H  = 3'd7;

   localparam logic [DIM_W-1:0] DIM_RESET = 14'd8192;

   // Intermediate terms of the gain saturate at +-2^62.
   localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(64'sh4000_0000_0000_0000);
   localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI;

   // Pipeline stage numbers.
   localparam int ST_DXY     = 1;
   localparam int ST_SQ      = 2;
   localparam int ST_R2      = 3;
   localparam int ST_KPP     = 4;
   localparam int ST_KSUM    = 5;
   localparam int ST_AT      = 6;
   localparam int ST_TPP     = 7;
   localparam int ST_TSUM    = 8;
   localparam int ST_B       = 9;
   localparam int ST_GAIN    = 10;
   localparam int ST_PPP     = 11;
   localparam int ST_POS     = 12;
   localparam int ST_INT     = 13;
   localparam int ST_OUT     = 14;
   localparam int NUM_STAGES = 14;

   typedef logic [NUM_STAGES:1] stage_en_type;

   typedef struct packed {
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
   } req_type;

   typedef struct packed {
      logic signed [INT_W-1:0] src_x_int;
      logic signed [INT_W-1:0] src_y_int;
      logic [FRAC_W-1:0]       frac_x;
      logic [FRAC_W-1:0]       frac_y;
      logic                    inside_res;
   } rsp_type;

   typedef struct packed {
      logic [CTR_W-1:0]      out_cx;
      logic [CTR_W-1:0]      out_cy;
      logic [CTR_W-1:0]      src_cx;
      logic [CTR_W-1:0]      src_cy;
      logic signed [K_W-1:0] k1;
      logic signed [K_W-1:0] k2;
      logic [DIM_W-1:0]      src_w;
      logic [DIM_W-1:0]      src_h;
   } cfg_type;

   function automatic logic signed [K_W-1:0] clamp_sl(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI;
      end else if (v < SAT_LO) begin
         r = SAT_LO;
      end else begin
         r = v;
      end
      return r[K_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== sv/rldr_csr.sv =====
`default_nettype none

module rldr_csr
   import rldr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_idx,
   input  wire logic [K_W-1:0]       csr_wdata,
   output cfg_type                   cfg
);

   localparam cfg_type CFG_RESET = '{
      out_cx: '0,
      out_cy: '0,
      src_cx: '0,
      src_cy: '0,
      k1:     '0,
      k2:     '0,
      src_w:  DIM_RESET,
      src_h:  DIM_RESET
   };

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx)
            REG_OUT_CX: cfg_in.out_cx = csr_wdata[CTR_W-1:0];
            REG_OUT_CY: cfg_in.out_cy = csr_wdata[CTR_W-1:0];
            REG_SRC_CX: cfg_in.src_cx = csr_wdata[CTR_W-1:0];
            REG_SRC_CY: cfg_in.src_cy = csr_wdata[CTR_W-1:0];
            REG_K1:     cfg_in.k1     = $signed(csr_wdata);
            REG_K2:     cfg_in.k2     = $signed(csr_wdata);
            REG_SRC_W:  cfg_in.src_w  = csr_wdata[DIM_W-1:0];
            REG_SRC_H:  cfg_in.src_h  = csr_wdata[DIM_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== sv/rldr_wmul.sv =====
`default_nettype none

module rldr_wmul
   import rldr_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     en_pp,
   input  wire logic                     en_sum,
   input  wire logic signed [K_W-1:0]    mult_a,
   input  wire logic [R2_W-1:0]          mult_b,
   output logic signed [PROD_W-1:0]      prod
);

   localparam int HALF_W = K_W / 2;
   localparam int BHI_W  = R2_W - HALF_W;

   logic [HALF_W-1:0]        a_lo;
   logic signed [HALF_W-1:0] a_hi;
   logic [HALF_W-1:0]        b_lo;
   logic [BHI_W-1:0]         b_hi;

   logic [2*HALF_W-1:0]             pp_ll_ff, pp_ll_in;
   logic signed [2*HALF_W:0]        pp_hl_ff, pp_hl_in;
   logic [HALF_W+BHI_W-1:0]         pp_lh_ff, pp_lh_in;
   logic signed [HALF_W+BHI_W:0]    pp_hh_ff, pp_hh_in;
   logic [PROD_W-1:0]               prod_ff, prod_in;

   assign a_lo = mult_a[HALF_W-1:0];
   assign a_hi = mult_a[K_W-1:HALF_W];
   assign b_lo = mult_b[HALF_W-1:0];
   assign b_hi = mult_b[R2_W-1:HALF_W];

   // Four partial products, each no wider than 33 by 33 bits.
   assign pp_ll_in = a_lo * b_lo;
   assign pp_hl_in = a_hi * $signed({1'b0, b_lo});
   assign pp_lh_in = a_lo * b_hi;
   assign pp_hh_in = a_hi * $signed({1'b0, b_hi});

   assign prod_in = {{(PROD_W-2*HALF_W){1'b0}}, pp_ll_ff}
                  + ({{(PROD_W-2*HALF_W-1){pp_hl_ff[2*HALF_W]}}, pp_hl_ff} << HALF_W)
                  + ({{(PROD_W-HALF_W-BHI_W){1'b0}}, pp_lh_ff} << HALF_W)
                  + ({{(PROD_W-HALF_W-BHI_W-1){pp_hh_ff[HALF_W+BHI_W]}}, pp_hh_ff}
                     << (2*HALF_W));

   always_ff @(posedge clock) begin
      if (en_pp) begin
         pp_ll_ff <= pp_ll_in;
         pp_hl_ff <= pp_hl_in;
         pp_lh_ff <= pp_lh_in;
         pp_hh_ff <= pp_hh_in;
      end
      if (en_sum) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = $signed(prod_ff);

endmodule

`default_nettype wire

// ===== sv/rldr_gain.sv =====
`default_nettype none

module rldr_gain
   import rldr_pkg::*;
(
   input  wire logic                   clock,
   input  wire stage_en_type           stage_en,
   input  wire cfg_type                cfg,
   input  wire logic signed [DX_W-1:0] dx,
   input  wire logic signed [DX_W-1:0] dy,
   output logic signed [K_W-1:0]       gain,
   output logic signed [DX_W-1:0]      dx_out,
   output logic signed [DX_W-1:0]      dy_out
);

   localparam logic [PROD_W-1:0] GAIN_ONE = PROD_W'(1) << GAIN_FRAC;

   logic signed [2*DX_W-1:0] sqx_full, sqy_full;
   logic [SQ_W-1:0]          sqx_ff, sqy_ff;
   logic [R2_W-1:0]          r2_ff, r2_in;
   logic [R2_W-1:0]          r2_st4_ff, r2_st5_ff, r2_st6_ff;

   logic signed [PROD_W-1:0] prod_a, prod_t, prod_b;
   logic signed [K_W-1:0]    a_st6_ff, a_st7_ff, a_st8_ff, a_st9_ff;
   logic signed [K_W-1:0]    t_st6_ff;
   logic signed [K_W-1:0]    b_st9_ff;
   logic signed [K_W-1:0]    gain_ff, gain_in;
   logic [PROD_W-1:0]        g_sum;

   logic signed [DX_W-1:0] dx_dl_ff [ST_SQ:ST_GAIN];
   logic signed [DX_W-1:0] dy_dl_ff [ST_SQ:ST_GAIN];

   assign sqx_full = dx * dx;
   assign sqy_full = dy * dy;
   assign r2_in    = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   rldr_wmul u_mul_k1 (
      .clock  (clock),
      .en_pp  (stage_en[ST_KPP]),
      .en_sum (stage_en[ST_KSUM]),
      .mult_a (cfg.k1),
      .mult_b (r2_ff),
      .prod   (prod_a)
   );

   rldr_wmul u_mul_k2 (
      .clock  (clock),
      .en_pp  (stage_en[ST_KPP]),
      .en_sum (stage_en[ST_KSUM]),
      .mult_a (cfg.k2),
      .mult_b (r2_ff),
      .prod   (prod_t)
   );

   // The k2 term needs a second product with r2 after its own saturation.
   rldr_wmul u_mul_t (
      .clock  (clock),
      .en_pp  (stage_en[ST_TPP]),
      .en_sum (stage_en[ST_TSUM]),
      .mult_a (t_st6_ff),
      .mult_b (r2_st6_ff),
      .prod   (prod_b)
   );

   assign g_sum = GAIN_ONE
                + {{(PROD_W-K_W){a_st9_ff[K_W-1]}}, a_st9_ff}
                + {{(PROD_W-K_W){b_st9_ff[K_W-1]}}, b_st9_ff};
   assign gain_in = clamp_sl($signed(g_sum));

   always_ff @(posedge clock) begin
      if (stage_en[ST_SQ]) begin
         sqx_ff <= sqx_full[SQ_W-1:0];
         sqy_ff <= sqy_full[SQ_W-1:0];
         dx_dl_ff[ST_SQ] <= dx;
         dy_dl_ff[ST_SQ] <= dy;
      end
      for (int s = ST_SQ + 1; s <= ST_GAIN; s++) begin
         if (stage_en[s]) begin
            dx_dl_ff[s] <= dx_dl_ff[s-1];
            dy_dl_ff[s] <= dy_dl_ff[s-1];
         end
      end
      if (stage_en[ST_R2]) begin
         r2_ff <= r2_in;
      end
      if (stage_en[ST_KPP]) begin
         r2_st4_ff <= r2_ff;
      end
      if (stage_en[ST_KSUM]) begin
         r2_st5_ff <= r2_st4_ff;
      end
      if (stage_en[ST_AT]) begin
         r2_st6_ff <= r2_st5_ff;
         a_st6_ff  <= clamp_sl(prod_a >>> GAIN_FRAC);
         t_st6_ff  <= clamp_sl(prod_t >>> T_SHIFT);
      end
      if (stage_en[ST_TPP]) begin
         a_st7_ff <= a_st6_ff;
      end
      if (stage_en[ST_TSUM]) begin
         a_st8_ff <= a_st7_ff;
      end
      if (stage_en[ST_B]) begin
         a_st9_ff <= a_st8_ff;
         b_st9_ff <= clamp_sl(prod_b >>> B_SHIFT);
      end
      if (stage_en[ST_GAIN]) begin
         gain_ff <= gain_in;
      end
   end

   assign gain   = gain_ff;
   assign dx_out = dx_dl_ff[ST_GAIN];
   assign dy_out = dy_dl_ff[ST_GAIN];

endmodule

`default_nettype wire

// ===== sv/rldr_axis.sv =====
`default_nettype none

module rldr_axis
   import rldr_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  wire logic                   clock,
   input  wire stage_en_type           stage_en,
   input  wire logic signed [DX_W-1:0] d,
   input  wire logic signed [K_W-1:0]  gain,
   input  wire logic [CTR_W-1:0]       center,
   output logic signed [INT_W-1:0]     pos_int,
   output logic [FRAC_W-1:0]           pos_frac
);

   localparam int HALF_W    = K_W / 2;
   localparam int PLO_W     = DX_W + HALF_W + 1;
   localparam int PHI_W     = DX_W + HALF_W;
   localparam int FRAC_LSB  = POS_FRAC - FRAC_BITS;
   localparam int FRAC_KEEP = (FRAC_BITS < FRAC_W) ? FRAC_BITS : FRAC_W;
   localparam logic [FRAC_W-1:0] FRAC_MASK = FRAC_W'((32'd1 << FRAC_KEEP) - 32'd1);
   localparam logic signed [POS_W-1:0] INT_HI = POS_W'(32'sd32767);
   localparam logic signed [POS_W-1:0] INT_LO = ~INT_HI;

   logic signed [PLO_W-1:0]  pp_lo_ff, pp_lo_in;
   logic signed [PHI_W-1:0]  pp_hi_ff, pp_hi_in;
   logic [POS_W-1:0]         p_ff, p_in;
   logic signed [POS_W-1:0]  p_int;
   logic                     sat_hi, sat_lo;
   logic signed [INT_W-1:0]  int_ff, int_in;
   logic [FRAC_W-1:0]        frac_ff, frac_in;

   assign pp_lo_in = d * $signed({1'b0, gain[HALF_W-1:0]});
   assign pp_hi_in = d * $signed(gain[K_W-1:HALF_W]);

   assign p_in = {{(POS_W-PLO_W){pp_lo_ff[PLO_W-1]}}, pp_lo_ff}
               + ({{(POS_W-PHI_W){pp_hi_ff[PHI_W-1]}}, pp_hi_ff} << HALF_W)
               + ({{(POS_W-CTR_W){1'b0}}, center} << GAIN_FRAC);

   assign p_int  = $signed(p_ff) >>> POS_FRAC;
   assign sat_hi = p_int > INT_HI;
   assign sat_lo = p_int < INT_LO;

   // A saturated coordinate carries no fraction.
   always_comb begin
      if (sat_hi) begin
         int_in  = INT_HI[INT_W-1:0];
         frac_in = '0;
      end else if (sat_lo) begin
         int_in  = INT_LO[INT_W-1:0];
         frac_in = '0;
      end else begin
         int_in  = p_int[INT_W-1:0];
         frac_in = p_ff[FRAC_LSB +: FRAC_W] & FRAC_MASK;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_PPP]) begin
         pp_lo_ff <= pp_lo_in;
         pp_hi_ff <= pp_hi_in;
      end
      if (stage_en[ST_POS]) begin
         p_ff <= p_in;
      end
      if (stage_en[ST_INT]) begin
         int_ff  <= int_in;
         frac_ff <= frac_in;
      end
   end

   assign pos_int  = int_ff;
   assign pos_frac = frac_ff;

endmodule

`default_nettype wire

// ===== sv/radial_lens_distortion_remap_top.sv =====
// Throughput: one coordinate per cycle, sustained while rsp_ready is high; the 14-stage
// pipeline holds one item per stage, and the three 64x35 gain products are split at
// bit 32 of each operand into four partial products.
// A stalled response holds only the stages from which every later stage is full; empty
// stages and the others still move.
// Reset clears all stage valid bits and loads the registers: centres, k1 and k2 to zero,
// source width and height to 8192.
`default_nettype none

module radial_lens_distortion_remap_top
   import rldr_pkg::*;
#(
   parameter int MAX_DIM   = 8192,
   parameter int FRAC_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_idx,
   input  wire logic [K_W-1:0]       csr_wdata
);

   localparam logic [DIM_W:0] MAX_DIM_C = (DIM_W+1)'(MAX_DIM);

   cfg_type      cfg;
   stage_en_type stage_en;
   logic [NUM_STAGES:1] vld_ff, vld_in;

   logic signed [DX_W-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic signed [DX_W-1:0]  dx_g, dy_g;
   logic signed [K_W-1:0]   gain;
   logic signed [INT_W-1:0] x_int, y_int;
   logic [FRAC_W-1:0]       x_frac, y_frac;
   logic [DIM_W:0]          w_lim, h_lim;
   logic                    x_ok, y_ok;
   rsp_type                 rsp_ff, rsp_in;

   rldr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // A stage may load when the response is taken or when it or any stage after it is empty.
   for (genvar g = 1; g <= NUM_STAGES; g++) begin : g_en
      assign stage_en[g] = rsp_ready | ~(&vld_ff[NUM_STAGES:g]);
   end

   always_comb begin
      vld_in = vld_ff;
      if (stage_en[ST_DXY]) begin
         vld_in[ST_DXY] = req_valid;
      end
      for (int s = ST_DXY + 1; s <= NUM_STAGES; s++) begin
         if (stage_en[s]) begin
            vld_in[s] = vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign dx_in = $signed({1'b0, req_data.out_x, 4'b0000}) - $signed({1'b0, cfg.out_cx});
   assign dy_in = $signed({1'b0, req_data.out_y, 4'b0000}) - $signed({1'b0, cfg.out_cy});

   always_ff @(posedge clock) begin
      if (stage_en[ST_DXY]) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
   end

   rldr_gain u_gain (
      .clock    (clock),
      .stage_en (stage_en),
      .cfg      (cfg),
      .dx       (dx_ff),
      .dy       (dy_ff),
      .gain     (gain),
      .dx_out   (dx_g),
      .dy_out   (dy_g)
   );

   rldr_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
      .clock    (clock),
      .stage_en (stage_en),
      .d        (dx_g),
      .gain     (gain),
      .center   (cfg.src_cx),
      .pos_int  (x_int),
      .pos_frac (x_frac)
   );

   rldr_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
      .clock    (clock),
      .stage_en (stage_en),
      .d        (dy_g),
      .gain     (gain),
      .center   (cfg.src_cy),
      .pos_int  (y_int),
      .pos_frac (y_frac)
   );

   // The 2x2 neighbourhood is inside when 0 <= int and int + 1 < limit on both axes.
   assign w_lim = ({1'b0, cfg.src_w} < MAX_DIM_C) ? {1'b0, cfg.src_w} : MAX_DIM_C;
   assign h_lim = ({1'b0, cfg.src_h} < MAX_DIM_C) ? {1'b0, cfg.src_h} : MAX_DIM_C;
   assign x_ok  = !x_int[INT_W-1]
                  && (({1'b0, x_int} + (INT_W+1)'(1)) < {{(INT_W-DIM_W){1'b0}}, w_lim});
   assign y_ok  = !y_int[INT_W-1]
                  && (({1'b0, y_int} + (INT_W+1)'(1)) < {{(INT_W-DIM_W){1'b0}}, h_lim});

   always_comb begin
      rsp_in.src_x_int  = x_int;
      rsp_in.src_y_int  = y_int;
      rsp_in.frac_x     = x_frac;
      rsp_in.frac_y     = y_frac;
      rsp_in.inside_res = x_ok && y_ok;
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_ready = stage_en[ST_DXY];
   assign rsp_valid = vld_ff[ST_OUT];
   assign rsp_data  = rsp_ff;

   a_full_when_blocked : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&vld_ff))
      else $error("request blocked while a pipeline stage is empty");

   a_reset_clears : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_transfer_enters : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[ST_DXY])
      else $error("accepted request did not enter the first stage");

   a_inside_nonneg : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.inside_res)
         |-> (!rsp_data.src_x_int[INT_W-1] && !rsp_data.src_y_int[INT_W-1]))
      else $error("inside flag set with a negative source coordinate");

endmodule

`default_nettype wire
